### hdl/pfe_pkg.sv
package pfe_pkg;

    // Action codes carried with each input transaction.
    typedef enum logic [1:0] {
        ACT_KEY    = 2'd0,
        ACT_FINISH = 2'd1,
        ACT_TEXT   = 2'd2,
        ACT_END    = 2'd3
    } t_action;

    localparam int LETTERS = 26;
    localparam int CELLS   = 25;
    localparam int SIDE    = 5;

    typedef logic [4:0] t_letter;
    typedef logic [4:0] t_cell;
    typedef logic [2:0] t_rc;

    localparam t_letter LETTER_I    = 5'd8;
    localparam t_letter LETTER_J    = 5'd9;
    localparam t_letter LETTER_X    = 5'd23;
    localparam t_letter LETTER_LAST = 5'd25;

    localparam logic [7:0] ASCII_UA = 8'h41;
    localparam logic [7:0] ASCII_UZ = 8'h5A;
    localparam logic [7:0] ASCII_LA = 8'h61;
    localparam logic [7:0] ASCII_LZ = 8'h7A;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic key_place;
        logic fill_start;
        logic fill_step;
        logic set_ready;
        logic pend_load;
        logic pair_text;
        logic pair_end;
        logic pos_sel_b;
        logic cap_pa;
        logic calc;
        logic sq_sel_e2;
        logic load_out;
        logic out_last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic square_ready;
        logic pend_valid;
        logic is_letter;
        logic sweep_last;
        logic out_free;
    } t_status;

    // Maps an ASCII byte to {is_letter, letter index}, with J folded into I.
    function automatic logic [5:0] normalise(input logic [7:0] code);
        logic [7:0] diff;
        logic       ok;
        t_letter    idx;
        diff = 8'd0;
        ok   = 1'b0;
        if (code >= ASCII_LA && code <= ASCII_LZ) begin
            diff = code - ASCII_LA;
            ok   = 1'b1;
        end else if (code >= ASCII_UA && code <= ASCII_UZ) begin
            diff = code - ASCII_UA;
            ok   = 1'b1;
        end
        idx = diff[4:0];
        if (idx == LETTER_J) begin
            idx = LETTER_I;
        end
        return {ok, idx};
    endfunction

    // Next row or column, wrapping around the square.
    function automatic t_rc inc_wrap(input t_rc x);
        return (x == t_rc'(SIDE - 1)) ? t_rc'(0) : t_rc'(x + t_rc'(1));
    endfunction

    // Row-major cell number of a row and column.
    function automatic t_cell cell_of(input t_rc row, input t_rc col);
        return t_cell'(t_cell'(row) * t_cell'(SIDE) + t_cell'(col));
    endfunction

endpackage

### hdl/pfe_ifs.sv
// Input channel: one action with its ASCII byte per transaction.
interface pfe_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] char_code;

    modport source (output valid, output action, output char_code, input ready);
    modport sink (input valid, input action, input char_code, output ready);
endinterface

// Output channel: one ciphertext letter per transaction.
interface pfe_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] cipher_letter;
    logic       last;

    modport source (output valid, output cipher_letter, output last, input ready);
    modport sink (input valid, input cipher_letter, input last, output ready);
endinterface

### hdl/playfair_cipher_encryptor_core.sv
// Playfair encryptor over a byte stream. Key bytes build the 5x5 square
// (uppercased, J folded into I, repeats and non-letters dropped); a finish
// command completes the square with the unused letters by sweeping the
// alphabet one letter a cycle, and holds the input until the sweep ends.
// Text bytes and end of message before the square is ready are dropped. A
// text byte that completes a pair, or an end of message that pads a lone
// letter with X, holds the input while the sequencer reads both letter
// positions and then both cipher letters through single-port stores, one
// read a cycle while the output is free. Each pair gives two output
// transactions, with last set on the second; output back-pressure stalls
// the sequencer before each load.
module playfair_cipher_encryptor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfe_in_if.sink      i_in,
    pfe_out_if.source   o_out
);

    pfe_pkg::t_cmd    cmd;
    pfe_pkg::t_status status;
    logic             in_ready;
    logic             out_valid;
    logic [6:0]       out_letter;
    logic             out_last;

    pfe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .i_action (pfe_pkg::t_action'(i_in.action)),
        .i_status (status),
        .o_ready  (in_ready),
        .o_cmd    (cmd)
    );

    pfe_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_char_code     (i_in.char_code),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (out_valid),
        .o_cipher_letter (out_letter),
        .o_out_last      (out_last)
    );

    assign i_in.ready          = in_ready;
    assign o_out.valid         = out_valid;
    assign o_out.cipher_letter = out_letter;
    assign o_out.last          = out_last;

`ifndef NO_ASSERTIONS
    // The alphabet sweep never runs once the square is complete.
    a_fill_before_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fill_step |-> !status.square_ready)
        else $error("fill sweep ran after the square was ready");

    // A result is loaded only when the output register can take it.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> status.out_free)
        else $error("output register overwritten before its transaction");

    // A pair starts only from a pending letter in a finished square.
    a_pair_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.pair_text || cmd.pair_end) |-> (status.pend_valid && status.square_ready))
        else $error("pair started without a pending letter");

    // The square becomes ready only at the end of the alphabet sweep.
    a_ready_after_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(status.square_ready) |-> $past(cmd.fill_step && status.sweep_last))
        else $error("square ready without a completed sweep");
`endif

endmodule

### hdl/pfe_datapath.sv
module pfe_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_char_code,
    input  pfe_pkg::t_cmd   i_cmd,
    output pfe_pkg::t_status o_status,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic [6:0]      o_cipher_letter,
    output logic            o_out_last
);

    // Key square and the reverse map from letter to {row, col}.
    logic [4:0] r_square   [pfe_pkg::CELLS];
    logic [5:0] r_position [pfe_pkg::LETTERS];

    logic [pfe_pkg::LETTERS-1:0] r_used;
    logic [4:0]        r_fill;
    pfe_pkg::t_rc      r_row;
    pfe_pkg::t_rc      r_col;
    pfe_pkg::t_letter  r_sweep;
    logic              r_ready;
    logic              r_pend_v;
    pfe_pkg::t_letter  r_pend_l;
    pfe_pkg::t_letter  r_a;
    pfe_pkg::t_letter  r_b;
    logic [5:0]        r_pos_rd;
    logic [5:0]        r_pa;
    pfe_pkg::t_cell    r_e1;
    pfe_pkg::t_cell    r_e2;
    logic [4:0]        r_sq_rd;
    logic              r_out_v;
    logic [6:0]        r_out_letter;
    logic              r_out_last;

    logic [5:0]        norm;
    logic              norm_ok;
    pfe_pkg::t_letter  norm_idx;
    logic              place_req;
    logic              place_we;
    pfe_pkg::t_letter  w_letter;
    pfe_pkg::t_letter  pos_addr;
    pfe_pkg::t_cell    sq_addr;
    pfe_pkg::t_rc      ra, ca, rb, cb;
    pfe_pkg::t_cell    n_e1;
    pfe_pkg::t_cell    n_e2;
    logic              out_free;

    assign norm     = pfe_pkg::normalise(i_char_code);
    assign norm_ok  = norm[5];
    assign norm_idx = norm[4:0];

    // A letter goes into the square only if it is new and a cell is left.
    assign place_req = (i_cmd.key_place & norm_ok)
                     | (i_cmd.fill_step & (r_sweep != pfe_pkg::LETTER_J));
    assign w_letter  = i_cmd.fill_step ? r_sweep : norm_idx;
    assign place_we  = place_req && !r_used[w_letter]
                     && (r_fill < 5'(pfe_pkg::CELLS));

    assign pos_addr = i_cmd.pos_sel_b ? r_b : r_a;
    assign sq_addr  = i_cmd.sq_sel_e2 ? r_e2 : r_e1;

    // Memory writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (place_we) begin
            r_square[r_fill]     <= w_letter;
            r_position[w_letter] <= {r_row, r_col};
        end
        r_pos_rd <= r_position[pos_addr];
        r_sq_rd  <= r_square[sq_addr];
    end

    // Row, column and rectangle rules on the two positions.
    always_comb begin
        ra = r_pa[5:3];
        ca = r_pa[2:0];
        rb = r_pos_rd[5:3];
        cb = r_pos_rd[2:0];
        if (ra == rb) begin
            n_e1 = pfe_pkg::cell_of(ra, pfe_pkg::inc_wrap(ca));
            n_e2 = pfe_pkg::cell_of(rb, pfe_pkg::inc_wrap(cb));
        end else if (ca == cb) begin
            n_e1 = pfe_pkg::cell_of(pfe_pkg::inc_wrap(ra), ca);
            n_e2 = pfe_pkg::cell_of(pfe_pkg::inc_wrap(rb), cb);
        end else begin
            n_e1 = pfe_pkg::cell_of(ra, cb);
            n_e2 = pfe_pkg::cell_of(rb, ca);
        end
    end

    // Square building state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_fill  <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_ready <= 1'b0;
            r_sweep <= '0;
        end else begin
            if (place_we) begin
                r_used[w_letter] <= 1'b1;
                r_fill           <= r_fill + 5'd1;
                if (r_col == pfe_pkg::t_rc'(pfe_pkg::SIDE - 1)) begin
                    r_col <= '0;
                    r_row <= r_row + 3'd1;
                end else begin
                    r_col <= r_col + 3'd1;
                end
            end
            if (i_cmd.fill_start) begin
                r_sweep <= '0;
            end else if (i_cmd.fill_step) begin
                r_sweep <= r_sweep + 5'd1;
            end
            if (i_cmd.set_ready) begin
                r_ready <= 1'b1;
            end
        end
    end

    // Pending letter and pair formation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_pend_l <= '0;
        end else begin
            if (i_cmd.pend_load) begin
                r_pend_v <= 1'b1;
                r_pend_l <= norm_idx;
            end else if (i_cmd.pair_text) begin
                // A doubled letter keeps its second copy pending.
                r_pend_v <= (norm_idx == r_pend_l);
            end else if (i_cmd.pair_end) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pair_text) begin
            r_a <= r_pend_l;
            r_b <= (norm_idx == r_pend_l) ? pfe_pkg::LETTER_X : norm_idx;
        end else if (i_cmd.pair_end) begin
            r_a <= r_pend_l;
            r_b <= pfe_pkg::LETTER_X;
        end
        if (i_cmd.cap_pa) begin
            r_pa <= r_pos_rd;
        end
        if (i_cmd.calc) begin
            r_e1 <= n_e1;
            r_e2 <= n_e2;
        end
    end

    // Output register; it frees when its transaction completes.
    assign out_free = !r_out_v || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_letter <= pfe_pkg::ASCII_UA[6:0] + 7'(r_sq_rd);
            r_out_last   <= i_cmd.out_last;
        end
    end

    assign o_status.square_ready = r_ready;
    assign o_status.pend_valid   = r_pend_v;
    assign o_status.is_letter    = norm_ok;
    assign o_status.sweep_last   = (r_sweep == pfe_pkg::LETTER_LAST);
    assign o_status.out_free     = out_free;

    assign o_out_valid     = r_out_v;
    assign o_cipher_letter = r_out_letter;
    assign o_out_last      = r_out_last;

endmodule

### hdl/pfe_ctrl.sv
module pfe_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  pfe_pkg::t_action i_action,
    input  pfe_pkg::t_status i_status,
    output logic             o_ready,
    output pfe_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_RD_A,
        S_RD_B,
        S_CALC,
        S_RD_E1,
        S_LD1,
        S_RD_E2,
        S_LD2
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands for the datapath.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    unique case (i_action)
                        pfe_pkg::ACT_KEY: begin
                            o_cmd.key_place = !i_status.square_ready;
                        end
                        pfe_pkg::ACT_FINISH: begin
                            if (!i_status.square_ready) begin
                                o_cmd.fill_start = 1'b1;
                                n_state          = S_FILL;
                            end
                        end
                        pfe_pkg::ACT_TEXT: begin
                            if (i_status.square_ready && i_status.is_letter) begin
                                if (i_status.pend_valid) begin
                                    o_cmd.pair_text = 1'b1;
                                    n_state         = S_RD_A;
                                end else begin
                                    o_cmd.pend_load = 1'b1;
                                end
                            end
                        end
                        pfe_pkg::ACT_END: begin
                            if (i_status.square_ready && i_status.pend_valid) begin
                                o_cmd.pair_end = 1'b1;
                                n_state        = S_RD_A;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_status.sweep_last) begin
                    o_cmd.set_ready = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_RD_A: begin
                n_state = S_RD_B;
            end
            S_RD_B: begin
                o_cmd.pos_sel_b = 1'b1;
                o_cmd.cap_pa    = 1'b1;
                n_state         = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_RD_E1;
            end
            S_RD_E1: begin
                n_state = S_LD1;
            end
            S_LD1: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_RD_E2;
                end
            end
            S_RD_E2: begin
                o_cmd.sq_sel_e2 = 1'b1;
                n_state         = S_LD2;
            end
            S_LD2: begin
                o_cmd.sq_sel_e2 = 1'b1;
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
